[src/upbf_pkg.sv]
// ----------------------------------------------------------------------------
// upbf_pkg
// Shared types, constants and rule tables for the URL path blacklist filter.
// ----------------------------------------------------------------------------
package upbf_pkg;

  localparam int BYTE_W      = 8;
  localparam int RULE_COUNT  = 10;
  localparam int HIST_BYTES  = 8;
  localparam int HIST_W      = HIST_BYTES * BYTE_W;
  localparam int WIN_W       = HIST_W + BYTE_W;
  localparam int EMIT_SLOTS  = 3;
  localparam int RULE_IDX_W  = 4;

  localparam logic [RULE_IDX_W-1:0] RULE_NONE = RULE_IDX_W'(RULE_COUNT);

  localparam logic [BYTE_W-1:0] CHAR_PCT = 8'h25;

  // escape decoder phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  // rule text, last character in the lowest byte
  localparam logic [WIN_W-1:0] RULE_TEXT [RULE_COUNT] = '{
    WIN_W'(".."),
    WIN_W'("//"),
    WIN_W'(".git"),
    WIN_W'(".ssh"),
    WIN_W'(".svn"),
    WIN_W'(".vscode"),
    WIN_W'(".htaccess"),
    WIN_W'("etc"),
    WIN_W'("php"),
    WIN_W'("<script>")
  };

  localparam int RULE_LEN [RULE_COUNT] = '{2, 2, 4, 4, 4, 7, 9, 3, 3, 8};

  // decoded bytes produced by one raw byte, slot 0 first
  typedef struct packed {
    logic [EMIT_SLOTS-1:0]             valid;
    logic [EMIT_SLOTS-1:0][BYTE_W-1:0] data;
  } emit_t;

  typedef struct packed {
    logic                  allowed;
    logic [RULE_IDX_W-1:0] first_rule;
  } verdict_t;

  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      v = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

  // window holds newest decoded byte in the low byte
  function automatic logic [RULE_COUNT-1:0] rules_match(input logic [WIN_W-1:0] win);
    logic [RULE_COUNT-1:0] hit;
    logic [WIN_W-1:0]      mask;
    hit = '0;
    for (int r = 0; r < RULE_COUNT; r++) begin
      mask   = (WIN_W'(1) << (BYTE_W * RULE_LEN[r])) - WIN_W'(1);
      hit[r] = (((win ^ RULE_TEXT[r]) & mask) == '0);
    end
    return hit;
  endfunction

endpackage

[src/url_path_blacklist_filter.sv]
// ----------------------------------------------------------------------------
// url_path_blacklist_filter
// Percent-decodes a URL path byte stream and checks it against fixed rules.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                                | tuser / tlast
//  s_axis   | in        | [7:0] path_byte                      | tlast = is_last
//  m_axis   | out       | [0] path_allowed, [4:1] first_rule   | -
//
//  One path byte per cycle but for a stalled last byte; the escape decode and
//  all ten rule comparators sit in one stage after the input register.
//  The verdict is registered as the last byte leaves the input register.
//  rst is synchronous and clears the decoder, history, rule hits and both
//  valid flags.
//  A held verdict stalls a last byte and the input behind it; earlier bytes flow.
// ----------------------------------------------------------------------------
module url_path_blacklist_filter import upbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] path_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] path_allowed, [4:1] first_rule, [7:5] zero
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              out_free;
  logic              fire;
  emit_t             emit;
  verdict_t          verdict;
  verdict_t          result;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  upbf_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .raw_byte (in_byte),
    .last     (in_last),
    .emit     (emit)
  );

  upbf_match u_match (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .last    (in_last),
    .emit    (emit),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      result <= verdict;
    end
  end

  assign m_axis_tdata = {3'b000, result.first_rule, result.allowed};

endmodule

[src/upbf_decode.sv]
// ----------------------------------------------------------------------------
// upbf_decode
// Percent-escape decoder: turns one raw byte into up to three decoded bytes.
// ----------------------------------------------------------------------------
module upbf_decode import upbf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [BYTE_W-1:0] raw_byte,
  input  logic              last,
  output emit_t             emit
);

  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [BYTE_W-1:0] high;
  logic [BYTE_W-1:0] high_next;
  logic              hex;

  assign hex = is_hex(raw_byte);

  always_comb begin
    emit       = '0;
    phase_next = phase;
    high_next  = high;
    case (phase)
      PH_IDLE: begin
        if (raw_byte == CHAR_PCT) begin
          if (last) begin
            emit.valid[0] = 1'b1;
            emit.data[0]  = CHAR_PCT;
          end else begin
            phase_next = PH_PCT;
          end
        end else begin
          emit.valid[0] = 1'b1;
          emit.data[0]  = raw_byte;
        end
      end
      PH_PCT: begin
        if (hex) begin
          if (last) begin
            emit.valid[1:0] = 2'b11;
            emit.data[0]    = CHAR_PCT;
            emit.data[1]    = raw_byte;
          end else begin
            phase_next = PH_DIG;
            high_next  = raw_byte;
          end
        end else begin
          emit.valid[0] = 1'b1;
          emit.data[0]  = CHAR_PCT;
          if (raw_byte == CHAR_PCT) begin
            if (last) begin
              emit.valid[1] = 1'b1;
              emit.data[1]  = CHAR_PCT;
            end
          end else begin
            emit.valid[1] = 1'b1;
            emit.data[1]  = raw_byte;
            phase_next    = PH_IDLE;
          end
        end
      end
      PH_DIG: begin
        if (hex) begin
          emit.valid[0] = 1'b1;
          emit.data[0]  = {hex_value(high), hex_value(raw_byte)};
          phase_next    = PH_IDLE;
        end else begin
          emit.valid[1:0] = 2'b11;
          emit.data[0]    = CHAR_PCT;
          emit.data[1]    = high;
          if (raw_byte == CHAR_PCT) begin
            if (last) begin
              emit.valid[2] = 1'b1;
              emit.data[2]  = CHAR_PCT;
            end else begin
              phase_next = PH_PCT;
            end
          end else begin
            emit.valid[2] = 1'b1;
            emit.data[2]  = raw_byte;
            phase_next    = PH_IDLE;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (last) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      high  <= '0;
    end else if (fire) begin
      phase <= phase_next;
      high  <= high_next;
    end
  end

endmodule

[src/upbf_match.sv]
// ----------------------------------------------------------------------------
// upbf_match
// Substring matcher: keeps the decoded history and the set of rules hit.
// ----------------------------------------------------------------------------
module upbf_match import upbf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  logic     last,
  input  emit_t    emit,
  output verdict_t verdict
);

  logic [HIST_W-1:0]     hist;
  logic [HIST_W-1:0]     hist_next;
  logic [RULE_COUNT-1:0] hits;
  logic [RULE_COUNT-1:0] hits_next;
  logic                  stopped;
  logic                  stopped_next;

  // decoded bytes of one raw byte, in order; a zero byte stops matching
  always_comb begin
    hist_next    = hist;
    hits_next    = hits;
    stopped_next = stopped;
    for (int k = 0; k < EMIT_SLOTS; k++) begin
      if (emit.valid[k] && !stopped_next) begin
        if (emit.data[k] == '0) begin
          stopped_next = 1'b1;
        end else begin
          hits_next = hits_next | rules_match({hist_next, emit.data[k]});
          hist_next = {hist_next[HIST_W-BYTE_W-1:0], emit.data[k]};
        end
      end
    end
  end

  always_comb begin
    verdict.allowed    = (hits_next == '0);
    verdict.first_rule = RULE_NONE;
    for (int r = RULE_COUNT - 1; r >= 0; r--) begin
      if (hits_next[r]) begin
        verdict.first_rule = RULE_IDX_W'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist    <= '0;
      hits    <= '0;
      stopped <= 1'b0;
    end else if (fire) begin
      if (last) begin
        hist    <= '0;
        hits    <= '0;
        stopped <= 1'b0;
      end else begin
        hist    <= hist_next;
        hits    <= hits_next;
        stopped <= stopped_next;
      end
    end
  end

endmodule

[src/upbf_checker.sv]
// ----------------------------------------------------------------------------
// upbf_checker
// Port-level checks for the URL path blacklist filter.
// ----------------------------------------------------------------------------
module upbf_checker import upbf_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_rule_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[4:1] <= RULE_NONE)
    else $error("rule index out of range");

  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[4:1] == RULE_NONE)))
    else $error("verdict and rule index disagree");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
    else $error("padding bits set");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind url_path_blacklist_filter upbf_checker u_checker (.*);

[tb/upbf_checker.sv]
// ----------------------------------------------------------------------------
// upbf_scoreboard
// Watches both streams of the URL path blacklist filter. Every accepted path
// byte runs through a local percent-decoder and rule scanner; on the last
// byte of a path the expected verdict is queued. Every verdict transfer is
// compared field by field with the oldest queued verdict.
// ----------------------------------------------------------------------------
module upbf_scoreboard import upbf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_data,
  output int         mismatches,
  output int         outstanding,
  output int         verdicts
);

  logic [1:0]            esc_phase;
  logic [7:0]            esc_hi;
  logic [HIST_W-1:0]     hist;
  logic [3:0]            hist_cnt;
  logic [RULE_COUNT-1:0] hits;
  logic                  nul_seen;

  verdict_t pending_verdicts[$];
  verdict_t got_v;
  verdict_t want_v;
  int       err_cnt;
  int       seen_cnt;

  // forbidden text, final character in the low byte
  function automatic logic [WIN_W-1:0] rule_text_of(input int r);
    case (r)
      0:       return WIN_W'("..");
      1:       return WIN_W'("//");
      2:       return WIN_W'(".git");
      3:       return WIN_W'(".ssh");
      4:       return WIN_W'(".svn");
      5:       return WIN_W'(".vscode");
      6:       return WIN_W'(".htaccess");
      7:       return WIN_W'("etc");
      8:       return WIN_W'("php");
      default: return WIN_W'("<script>");
    endcase
  endfunction

  function automatic int rule_len_of(input logic [WIN_W-1:0] txt);
    int n;
    n = 0;
    for (int k = 0; k < WIN_W / 8; k++) begin
      if (txt[8*k +: 8] != 8'h00) n = k + 1;
    end
    return n;
  endfunction

  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // letters carry bit 6; their low nibble is 1..6
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    return c[3:0] + (c[6] ? 4'd9 : 4'd0);
  endfunction

  task automatic clear_path();
    esc_phase = PH_IDLE;
    esc_hi    = 8'h00;
    hist      = '0;
    hist_cnt  = 4'd0;
    hits      = '0;
    nul_seen  = 1'b0;
  endtask

  task automatic scan_decoded(input logic [7:0] c);
    logic [WIN_W-1:0] txt;
    int               len;
    logic             ok;
    if (nul_seen) return;
    if (c == 8'h00) begin
      nul_seen = 1'b1;
      return;
    end
    for (int r = 0; r < RULE_COUNT; r++) begin
      txt = rule_text_of(r);
      len = rule_len_of(txt);
      ok  = (txt[7:0] == c) && (int'(hist_cnt) >= len - 1);
      for (int i = 1; i < len; i++) begin
        if (hist[8*(i-1) +: 8] != txt[8*i +: 8]) ok = 1'b0;
      end
      if (ok) hits[r] = 1'b1;
    end
    hist = {hist[HIST_W-9:0], c};
    if (hist_cnt < 4'd8) hist_cnt = hist_cnt + 4'd1;
  endtask

  task automatic decode_raw(input logic [7:0] c);
    case (esc_phase)
      PH_PCT: begin
        if (hex_digit(c)) begin
          esc_hi    = c;
          esc_phase = PH_DIG;
          return;
        end
        scan_decoded(CHAR_PCT);
        esc_phase = PH_IDLE;
      end
      PH_DIG: begin
        if (hex_digit(c)) begin
          scan_decoded({nibble_of(esc_hi), nibble_of(c)});
          esc_phase = PH_IDLE;
          esc_hi    = 8'h00;
          return;
        end
        scan_decoded(CHAR_PCT);
        scan_decoded(esc_hi);
        esc_phase = PH_IDLE;
        esc_hi    = 8'h00;
      end
      default: esc_phase = PH_IDLE;
    endcase
    if (c == CHAR_PCT) begin
      esc_phase = PH_PCT;
      return;
    end
    scan_decoded(c);
  endtask

  task automatic close_path();
    verdict_t v;
    case (esc_phase)
      PH_PCT: scan_decoded(CHAR_PCT);
      PH_DIG: begin
        scan_decoded(CHAR_PCT);
        scan_decoded(esc_hi);
      end
      default: ;
    endcase
    v.allowed    = (hits == '0);
    v.first_rule = RULE_NONE;
    for (int r = RULE_COUNT - 1; r >= 0; r--) begin
      if (hits[r]) v.first_rule = RULE_IDX_W'(r);
    end
    pending_verdicts.push_back(v);
    clear_path();
  endtask

  task automatic report(input string what, input int want, input int got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("verdict %0d: %s expected %0h got %0h", seen_cnt, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_path();
      pending_verdicts.delete();
      err_cnt  = 0;
      seen_cnt = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen_cnt++;
        got_v.allowed    = out_data[0];
        got_v.first_rule = out_data[4:1];
        if (pending_verdicts.size() == 0) begin
          report("unexpected verdict, tdata", 0, out_data);
        end else begin
          want_v = pending_verdicts.pop_front();
          if (got_v.allowed != want_v.allowed) begin
            report("path_allowed", want_v.allowed, got_v.allowed);
          end
          if (got_v.first_rule != want_v.first_rule) begin
            report("first_rule", want_v.first_rule, got_v.first_rule);
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_raw(in_data);
        if (in_last) close_path();
      end
    end
    mismatches  <= err_cnt;
    outstanding <= pending_verdicts.size();
    verdicts    <= seen_cnt;
  end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the URL path blacklist filter: a short directed set of paths,
// then random paths built from rule words, encoded rule words, valid and
// broken escapes, zero bytes and raw noise, with random gaps on the input
// and random back-pressure on the verdict stream. Checking is done by
// upbf_scoreboard; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import upbf_pkg::*;

  localparam int TARGET_BYTES = 1650;
  localparam int CALM_FROM    = 1450;
  localparam int LIMIT        = 400000;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tready = 1'b0;
  wire        s_axis_tready;
  wire        m_axis_tvalid;
  wire  [7:0] m_axis_tdata;

  int         mismatches;
  int         outstanding;
  int         verdicts;
  int         bytes_sent  = 0;
  int         paths_sent  = 0;
  int         cycle_count = 0;
  logic       calm        = 1'b0;
  logic       steady      = 1'b0;
  logic [7:0] path_q[$];

  url_path_blacklist_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  upbf_scoreboard u_scoreboard (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_data     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .verdicts    (verdicts)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic string rule_word(input int r);
    case (r)
      0:       return "..";
      1:       return "//";
      2:       return ".git";
      3:       return ".ssh";
      4:       return ".svn";
      5:       return ".vscode";
      6:       return ".htaccess";
      7:       return "etc";
      8:       return "php";
      default: return "<script>";
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) path_q.push_back(s[k]);
  endtask

  task automatic add_escape(input logic [7:0] v);
    path_q.push_back(CHAR_PCT);
    path_q.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
    path_q.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
  endtask

  task automatic add_fragment();
    string alpha;
    string junk;
    string w;
    int    n;
    alpha = "abcdefghipstvw/.<>-_";
    junk  = "g%/.zG-x<";
    case ($urandom_range(0, 15))
      0, 1, 2: add_text(rule_word($urandom_range(0, 9)));
      3, 4: begin
        w = rule_word($urandom_range(0, 9));
        for (int k = 0; k < w.len(); k++) begin
          if ($urandom_range(0, 2) == 0) add_escape(w[k]);
          else path_q.push_back(w[k]);
        end
      end
      5, 6, 7: begin
        n = $urandom_range(1, 4);
        repeat (n) path_q.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) path_q.push_back(8'($urandom_range(0, 255)));
      end
      9: add_escape(8'($urandom_range(0, 255)));
      10: begin
        path_q.push_back(CHAR_PCT);
        path_q.push_back(junk[$urandom_range(0, junk.len() - 1)]);
      end
      11: begin
        path_q.push_back(CHAR_PCT);
        path_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        path_q.push_back(junk[$urandom_range(0, junk.len() - 1)]);
      end
      12: begin
        if ($urandom_range(0, 1) == 0) path_q.push_back(8'h00);
        else add_escape(8'h00);
      end
      13: add_text("%%");
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) path_q.push_back($urandom_range(0, 1) ? 8'h2e : 8'h2f);
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && !steady && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_path();
    steady = ($urandom_range(0, 3) == 0);
    for (int k = 0; k < path_q.size(); k++) begin
      send_byte(path_q[k], k == path_q.size() - 1);
    end
    paths_sent++;
    if (bytes_sent >= CALM_FROM) calm = 1'b1;
    path_q.delete();
  endtask

  // verdict-side back-pressure
  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (calm) begin
        m_axis_tready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        hold = $urandom_range(1, 9) - 1;
      end else begin
        m_axis_tready <= 1'b1;
        hold = $urandom_range(0, 24);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("url_path_blacklist_filter verification failed");
    $finish;
  end

  initial begin : stim
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: byte extremes as one-byte paths, cut-off escapes, encoded
    // rule, broken escape runs, zero byte ending the scan
    path_q.push_back(8'hff);
    send_path();
    path_q.push_back(8'h00);
    send_path();
    add_text("%");
    send_path();
    add_text("%4");
    send_path();
    add_text("%2e%2E");
    send_path();
    add_text("%%2f/");
    send_path();
    add_text("%00..");
    send_path();
    add_text("%4g");
    send_path();

    while (bytes_sent < TARGET_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        repeat (n) path_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) add_fragment();
        if ($urandom_range(0, 7) == 0) begin
          path_q.push_back(CHAR_PCT);
          if ($urandom_range(0, 1) == 0) begin
            path_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
          end
        end
      end
      send_path();
    end
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d path bytes in %0d paths; %0d verdicts compared, %0d mismatches.",
             bytes_sent, paths_sent, verdicts, mismatches);
    $display("Paths mixed rule words, encoded rules, broken and cut-off escapes, zero bytes.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("url_path_blacklist_filter verification clean");
    end else begin
      $display("url_path_blacklist_filter verification failed");
    end
    $finish;
  end

endmodule
